FILE: rtl/rvd_pkg.sv
package rvd_pkg;

   // Largest NAL unit that fragment reassembly may build.
   localparam int MAX_UNIT_BYTES = 1048576;
   // Unit byte counter width: holds a full single or aggregated unit and the fragment limit.
   localparam int CNT_W = $clog2(((MAX_UNIT_BYTES > 65536) ? MAX_UNIT_BYTES : 65536) + 1);

   // Result kinds.
   localparam logic [1:0] KIND_DATA   = 2'd0;
   localparam logic [1:0] KIND_END    = 2'd1;
   localparam logic [1:0] KIND_ABORT  = 2'd2;
   localparam logic [1:0] KIND_REJECT = 2'd3;

   // Packet modes.
   localparam logic [1:0] MODE_IDLE   = 2'd0;
   localparam logic [1:0] MODE_SINGLE = 2'd1;
   localparam logic [1:0] MODE_AGG    = 2'd2;
   localparam logic [1:0] MODE_FRAG   = 2'd3;

   // Aggregation packet phases.
   localparam logic [2:0] AGG_SIZE_HI0 = 3'd0;
   localparam logic [2:0] AGG_DONL     = 3'd1;
   localparam logic [2:0] AGG_SIZE_HI  = 3'd2;
   localparam logic [2:0] AGG_SIZE_LO  = 3'd3;
   localparam logic [2:0] AGG_DATA     = 3'd4;

   // NAL unit types of the payload header.
   localparam logic [4:0] TYPE_AP = 5'd28;
   localparam logic [4:0] TYPE_FU = 5'd29;

   // Results of one input item, and the depth of the queue between front and back.
   localparam int MAX_RES = 4;
   localparam int QD      = 4;

   typedef struct packed {
      logic [7:0]  payload_byte;
      logic        packet_first;
      logic        packet_last;
      logic [15:0] rtp_seq;
      logic [31:0] rtp_timestamp;
      logic [15:0] payload_length;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  unit_byte;
      logic        unit_first;
      logic        lost_flag;
      logic [31:0] unit_timestamp;
      logic [20:0] unit_length;
   } rsp_type;

   typedef struct packed {
      logic [2:0]                 count;
      rsp_type [MAX_RES-1:0]      res;
   } bundle_type;

   typedef struct packed {
      logic       valid;
      bundle_type bundle;
   } fq_push_type;

endpackage

FILE: rtl/rtp_vvc_depacketizer_core.sv
// Channel   Ports                          Direction  Transfer when
// input     req_push req_full req_item     in         req_push && !req_full
// result    rsp_empty rsp_pop rsp_item     out        rsp_pop && !rsp_empty
// control   csr_we csr_wdata               in         csr_we
//
// One payload byte is taken per cycle while req_full is low; the front works out all
// of its results (zero to four) in that cycle and queues any of them as one bundle.
// Results leave one per cycle while rsp_pop is high, from a four-bundle queue; req_full rises when it is full.
// Reset is synchronous and clears all packet, unit and queue state.
module rtp_vvc_depacketizer_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  rvd_pkg::req_type req_item,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output rvd_pkg::rsp_type rsp_item,
   input  logic             csr_we,
   input  logic             csr_wdata
);

   rvd_pkg::fq_push_type push;
   rvd_pkg::bundle_type  head;
   logic                 q_full;
   logic                 q_empty;
   logic                 q_pop;

   assign req_full = q_full;

   rvd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_push && !q_full),
      .item      (req_item),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .push      (push)
   );

   rvd_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (q_pop),
      .full  (q_full),
      .empty (q_empty),
      .head  (head)
   );

   rvd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .head      (head),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_item  (rsp_item)
   );

`ifndef NO_ASSERTIONS
   // The front never offers a bundle the queue cannot take.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> !q_full) else $error("bundle pushed into a full queue");

   // Nothing is waiting right after reset.
   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> rsp_empty) else $error("result present after reset");

   // Only data results carry a unit byte.
   a_byte_only_data: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_item.kind != rvd_pkg::KIND_DATA) |-> rsp_item.unit_byte == 8'd0)
      else $error("unit byte on a non-data result");
`endif

endmodule

FILE: rtl/rvd_front.sv
module rvd_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  rvd_pkg::req_type     item,
   input  logic                 csr_we,
   input  logic                 csr_wdata,
   output rvd_pkg::fq_push_type push
);

   logic                      use_donl_ff;
   logic                      seeded_ff, seeded_in;
   logic                      lost_ff, lost_in;
   logic [15:0]               last_seq_ff, last_seq_in;
   logic                      open_ff, open_in;
   logic [rvd_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic [7:0]                hdr0_ff, hdr0_in;
   logic [7:0]                hdr1_ff, hdr1_in;
   logic [1:0]                mode_ff, mode_in;
   logic [15:0]               pos_ff, pos_in;
   logic [15:0]               left_ff, left_in;
   logic [2:0]                phase_ff, phase_in;
   logic [15:0]               agg_left_ff, agg_left_in;
   logic                      agg_first_ff, agg_first_in;
   logic [31:0]               ptime_ff, ptime_in;
   logic [1:0]                frag_bits_ff, frag_bits_in;
   rvd_pkg::bundle_type       bundle_in;

   // Classify one byte and work out every result it causes, plus the next state.
   always_comb begin
      logic [2:0]                n;
      logic [15:0]               rem;
      logic [15:0]               pos;
      logic [15:0]               len;
      logic [15:0]               need;
      logic [15:0]               extra;
      logic [15:0]               dlen;
      logic [rvd_pkg::CNT_W:0]   base;
      logic                      start;
      n = 3'd0;
      bundle_in = '0;
      seeded_in = seeded_ff;
      lost_in = lost_ff;
      last_seq_in = last_seq_ff;
      open_in = open_ff;
      cnt_in = cnt_ff;
      hdr0_in = hdr0_ff;
      hdr1_in = hdr1_ff;
      mode_in = mode_ff;
      pos_in = pos_ff;
      left_in = left_ff;
      phase_in = phase_ff;
      agg_left_in = agg_left_ff;
      agg_first_in = agg_first_ff;
      ptime_in = ptime_ff;
      frag_bits_in = frag_bits_ff;
      rem = left_ff;
      pos = pos_ff;
      len = '0;
      need = '0;
      extra = '0;
      dlen = '0;
      base = '0;
      start = 1'b0;

      if (item.packet_first) begin
         // A new packet closes the one still in progress.
         if (mode_in != rvd_pkg::MODE_IDLE) begin
            if (mode_in == rvd_pkg::MODE_SINGLE) begin
               if (pos_in >= 16'd2) begin
                  bundle_in.res[n[1:0]] = '{kind: rvd_pkg::KIND_END, unit_byte: 8'd0,
                     unit_first: 1'b0, lost_flag: lost_in, unit_timestamp: ptime_in,
                     unit_length: 21'(cnt_in)};
                  n = n + 3'd1;
                  lost_in = 1'b0;
                  open_in = 1'b0;
                  cnt_in = '0;
               end
            end else if (mode_in == rvd_pkg::MODE_AGG) begin
               if (phase_in == rvd_pkg::AGG_DATA && agg_left_in != 16'd0) begin
                  if (open_in) begin
                     bundle_in.res[n[1:0]] = '{kind: rvd_pkg::KIND_ABORT, default: '0};
                     n = n + 3'd1;
                  end
                  open_in = 1'b0;
                  cnt_in = '0;
                  lost_in = 1'b1;
               end else if (phase_in >= rvd_pkg::AGG_DONL && phase_in <= rvd_pkg::AGG_SIZE_LO) begin
                  lost_in = 1'b1;
               end
            end else begin
               if (pos_in >= 16'd3 && open_in && frag_bits_in[0]) begin
                  bundle_in.res[n[1:0]] = '{kind: rvd_pkg::KIND_END, unit_byte: 8'd0,
                     unit_first: 1'b0, lost_flag: lost_in, unit_timestamp: ptime_in,
                     unit_length: 21'(cnt_in)};
                  n = n + 3'd1;
                  lost_in = 1'b0;
                  open_in = 1'b0;
                  cnt_in = '0;
               end
            end
            mode_in = rvd_pkg::MODE_IDLE;
         end
         if (item.payload_length < (use_donl_ff ? 16'd5 : 16'd3)) begin
            // Too short to hold a payload header.
            bundle_in.res[n[1:0]] = '{kind: rvd_pkg::KIND_REJECT, default: '0};
            n = n + 3'd1;
            mode_in = rvd_pkg::MODE_IDLE;
         end else begin
            if (!seeded_in) begin
               seeded_in = 1'b1;
               last_seq_in = item.rtp_seq - 16'd1;
            end
            if (item.rtp_seq != last_seq_in + 16'd1) begin
               lost_in = 1'b1;
               if (open_in) begin
                  bundle_in.res[n[1:0]] = '{kind: rvd_pkg::KIND_ABORT, default: '0};
                  n = n + 3'd1;
               end
               open_in = 1'b0;
               cnt_in = '0;
            end
            last_seq_in = item.rtp_seq;
            ptime_in = item.rtp_timestamp;
            hdr0_in = item.payload_byte;
            pos_in = 16'd1;
            left_in = item.payload_length - 16'd1;
            phase_in = rvd_pkg::AGG_SIZE_HI0;
            agg_first_in = 1'b1;
            frag_bits_in = 2'd0;
            // A one-byte packet carries nothing and is simply closed.
            if (item.packet_last || left_in == 16'd0) mode_in = rvd_pkg::MODE_IDLE;
            else mode_in = rvd_pkg::MODE_SINGLE;
         end
      end else if (mode_ff != rvd_pkg::MODE_IDLE) begin
         if (mode_ff == rvd_pkg::MODE_SINGLE) begin
            if (pos == 16'd1) begin
               // Second header byte decides the packet type.
               hdr1_in = item.payload_byte;
               if (item.payload_byte[7:3] == rvd_pkg::TYPE_AP) begin
                  mode_in = rvd_pkg::MODE_AGG;
                  phase_in = rvd_pkg::AGG_SIZE_HI0;
               end else if (item.payload_byte[7:3] == rvd_pkg::TYPE_FU) begin
                  mode_in = rvd_pkg::MODE_FRAG;
               end else begin
                  if (open_in) begin
                     bundle_in.res[n[1:0]] = '{kind: rvd_pkg::KIND_ABORT, default: '0};
                     n = n + 3'd1;
                  end
                  open_in = 1'b1;
                  bundle_in.res[n[1:0]] = '{kind: rvd_pkg::KIND_DATA, unit_byte: hdr0_ff,
                     unit_first: 1'b1, default: '0};
                  n = n + 3'd1;
                  bundle_in.res[n[1:0]] = '{kind: rvd_pkg::KIND_DATA,
                     unit_byte: item.payload_byte, default: '0};
                  n = n + 3'd1;
                  cnt_in = rvd_pkg::CNT_W'(2);
               end
            end else begin
               bundle_in.res[n[1:0]] = '{kind: rvd_pkg::KIND_DATA, unit_byte: item.payload_byte,
                  unit_first: (cnt_in == '0), default: '0};
               n = n + 3'd1;
               cnt_in = cnt_in + rvd_pkg::CNT_W'(1);
            end
         end else if (mode_ff == rvd_pkg::MODE_AGG) begin
            // Aggregation packet: optional DONL or DOND, 16-bit size, then the unit.
            case (phase_ff)
               rvd_pkg::AGG_SIZE_HI0: begin
                  need = 16'd2 + (use_donl_ff ? (agg_first_ff ? 16'd2 : 16'd1) : 16'd0);
                  if (rem <= need) begin
                     mode_in = rvd_pkg::MODE_IDLE;
                  end else if (use_donl_ff) begin
                     phase_in = agg_first_ff ? rvd_pkg::AGG_DONL : rvd_pkg::AGG_SIZE_HI;
                  end else begin
                     agg_left_in = {item.payload_byte, 8'd0};
                     phase_in = rvd_pkg::AGG_SIZE_LO;
                  end
               end
               rvd_pkg::AGG_DONL: begin
                  phase_in = rvd_pkg::AGG_SIZE_HI;
               end
               rvd_pkg::AGG_SIZE_HI: begin
                  agg_left_in = {item.payload_byte, 8'd0};
                  phase_in = rvd_pkg::AGG_SIZE_LO;
               end
               rvd_pkg::AGG_SIZE_LO: begin
                  len = agg_left_ff | {8'd0, item.payload_byte};
                  if (open_in) begin
                     bundle_in.res[n[1:0]] = '{kind: rvd_pkg::KIND_ABORT, default: '0};
                     n = n + 3'd1;
                  end
                  open_in = 1'b0;
                  cnt_in = '0;
                  if (len < 16'd3 || rem == 16'd0 || len > rem - 16'd1) begin
                     lost_in = 1'b1;
                     bundle_in.res[n[1:0]] = '{kind: rvd_pkg::KIND_REJECT, default: '0};
                     n = n + 3'd1;
                     phase_in = rvd_pkg::AGG_SIZE_HI0;
                     mode_in = rvd_pkg::MODE_IDLE;
                  end else begin
                     open_in = 1'b1;
                     agg_left_in = len;
                     phase_in = rvd_pkg::AGG_DATA;
                  end
               end
               default: begin
                  bundle_in.res[n[1:0]] = '{kind: rvd_pkg::KIND_DATA, unit_byte: item.payload_byte,
                     unit_first: (cnt_in == '0), default: '0};
                  n = n + 3'd1;
                  cnt_in = cnt_in + rvd_pkg::CNT_W'(1);
                  if (agg_left_in != 16'd0) agg_left_in = agg_left_in - 16'd1;
                  if (agg_left_in == 16'd0) begin
                     bundle_in.res[n[1:0]] = '{kind: rvd_pkg::KIND_END, unit_byte: 8'd0,
                        unit_first: 1'b0, lost_flag: lost_in, unit_timestamp: ptime_in,
                        unit_length: 21'(cnt_in)};
                     n = n + 3'd1;
                     lost_in = 1'b0;
                     open_in = 1'b0;
                     cnt_in = '0;
                     phase_in = rvd_pkg::AGG_SIZE_HI0;
                     agg_first_in = 1'b0;
                  end
               end
            endcase
         end else begin
            if (pos == 16'd2) begin
               // Fragment header: check the size limit, then start or continue the unit.
               extra = use_donl_ff ? 16'd2 : 16'd0;
               dlen = (rem >= 16'd1 + extra) ? rem - 16'd1 - extra : 16'd0;
               start = item.payload_byte[7];
               base = start ? (rvd_pkg::CNT_W+1)'(2) :
                      (open_ff ? {1'b0, cnt_ff} : '0);
               if (base + (rvd_pkg::CNT_W+1)'(dlen) >
                   (rvd_pkg::CNT_W+1)'(rvd_pkg::MAX_UNIT_BYTES)) begin
                  bundle_in.res[n[1:0]] = '{kind: rvd_pkg::KIND_REJECT, default: '0};
                  n = n + 3'd1;
                  mode_in = rvd_pkg::MODE_IDLE;
               end else if (start) begin
                  if (open_in) begin
                     bundle_in.res[n[1:0]] = '{kind: rvd_pkg::KIND_ABORT, default: '0};
                     n = n + 3'd1;
                  end
                  open_in = 1'b1;
                  bundle_in.res[n[1:0]] = '{kind: rvd_pkg::KIND_DATA, unit_byte: hdr0_ff,
                     unit_first: 1'b1, default: '0};
                  n = n + 3'd1;
                  bundle_in.res[n[1:0]] = '{kind: rvd_pkg::KIND_DATA,
                     unit_byte: {item.payload_byte[4:0], hdr1_ff[2:0]}, default: '0};
                  n = n + 3'd1;
                  cnt_in = rvd_pkg::CNT_W'(2);
                  frag_bits_in = {1'b1, item.payload_byte[6]};
               end else if (!open_ff) begin
                  lost_in = 1'b1;
                  mode_in = rvd_pkg::MODE_IDLE;
               end else begin
                  frag_bits_in = {1'b0, item.payload_byte[6]};
               end
            end else if (pos >= (use_donl_ff ? 16'd5 : 16'd3)) begin
               bundle_in.res[n[1:0]] = '{kind: rvd_pkg::KIND_DATA, unit_byte: item.payload_byte,
                  unit_first: (cnt_in == '0), default: '0};
               n = n + 3'd1;
               cnt_in = cnt_in + rvd_pkg::CNT_W'(1);
            end
         end

         pos_in = pos + 16'd1;
         left_in = (rem != 16'd0) ? rem - 16'd1 : 16'd0;

         // Packet end by the last flag or by the length running out.
         if (mode_in != rvd_pkg::MODE_IDLE && (item.packet_last || left_in == 16'd0)) begin
            if (mode_in == rvd_pkg::MODE_SINGLE) begin
               if (pos_in >= 16'd2) begin
                  bundle_in.res[n[1:0]] = '{kind: rvd_pkg::KIND_END, unit_byte: 8'd0,
                     unit_first: 1'b0, lost_flag: lost_in, unit_timestamp: ptime_in,
                     unit_length: 21'(cnt_in)};
                  n = n + 3'd1;
                  lost_in = 1'b0;
                  open_in = 1'b0;
                  cnt_in = '0;
               end
            end else if (mode_in == rvd_pkg::MODE_AGG) begin
               if (phase_in == rvd_pkg::AGG_DATA && agg_left_in != 16'd0) begin
                  if (open_in) begin
                     bundle_in.res[n[1:0]] = '{kind: rvd_pkg::KIND_ABORT, default: '0};
                     n = n + 3'd1;
                  end
                  open_in = 1'b0;
                  cnt_in = '0;
                  lost_in = 1'b1;
               end else if (phase_in >= rvd_pkg::AGG_DONL && phase_in <= rvd_pkg::AGG_SIZE_LO) begin
                  lost_in = 1'b1;
               end
            end else begin
               if (pos_in >= 16'd3 && open_in && frag_bits_in[0]) begin
                  bundle_in.res[n[1:0]] = '{kind: rvd_pkg::KIND_END, unit_byte: 8'd0,
                     unit_first: 1'b0, lost_flag: lost_in, unit_timestamp: ptime_in,
                     unit_length: 21'(cnt_in)};
                  n = n + 3'd1;
                  lost_in = 1'b0;
                  open_in = 1'b0;
                  cnt_in = '0;
               end
            end
            mode_in = rvd_pkg::MODE_IDLE;
         end
      end
      bundle_in.count = n;
   end

   assign push.valid  = accept && (bundle_in.count != 3'd0);
   assign push.bundle = bundle_in;

   // Packet and unit state advances on each transfer.
   always_ff @(posedge clock) begin
      if (reset) begin
         use_donl_ff  <= 1'b0;
         seeded_ff    <= 1'b0;
         lost_ff      <= 1'b0;
         last_seq_ff  <= '0;
         open_ff      <= 1'b0;
         cnt_ff       <= '0;
         hdr0_ff      <= '0;
         hdr1_ff      <= '0;
         mode_ff      <= rvd_pkg::MODE_IDLE;
         pos_ff       <= '0;
         left_ff      <= '0;
         phase_ff     <= rvd_pkg::AGG_SIZE_HI0;
         agg_left_ff  <= '0;
         agg_first_ff <= 1'b1;
         ptime_ff     <= '0;
         frag_bits_ff <= '0;
      end else begin
         if (csr_we) use_donl_ff <= csr_wdata;
         if (accept) begin
            seeded_ff    <= seeded_in;
            lost_ff      <= lost_in;
            last_seq_ff  <= last_seq_in;
            open_ff      <= open_in;
            cnt_ff       <= cnt_in;
            hdr0_ff      <= hdr0_in;
            hdr1_ff      <= hdr1_in;
            mode_ff      <= mode_in;
            pos_ff       <= pos_in;
            left_ff      <= left_in;
            phase_ff     <= phase_in;
            agg_left_ff  <= agg_left_in;
            agg_first_ff <= agg_first_in;
            ptime_ff     <= ptime_in;
            frag_bits_ff <= frag_bits_in;
         end
      end
   end

endmodule

FILE: rtl/rvd_queue.sv
module rvd_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  rvd_pkg::fq_push_type push,
   input  logic                 pop,
   output logic                 full,
   output logic                 empty,
   output rvd_pkg::bundle_type  head
);

   localparam int PW = $clog2(rvd_pkg::QD);

   rvd_pkg::bundle_type mem_ff [rvd_pkg::QD];
   logic [PW-1:0]       wr_ff, wr_in;
   logic [PW-1:0]       rd_ff, rd_in;
   logic [PW:0]         count_ff, count_in;
   logic                do_push, do_pop;

   assign full    = (count_ff == (PW+1)'(rvd_pkg::QD));
   assign empty   = (count_ff == '0);
   assign head    = mem_ff[rd_ff];
   assign do_push = push.valid && !full;
   assign do_pop  = pop && !empty;

   // Pointer and fill count updates.
   always_comb begin
      wr_in    = do_push ? wr_ff + PW'(1) : wr_ff;
      rd_in    = do_pop ? rd_ff + PW'(1) : rd_ff;
      count_in = count_ff + (PW+1)'(do_push) - (PW+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   // Bundle storage.
   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ff] <= push.bundle;
   end

endmodule

FILE: rtl/rvd_back.sv
module rvd_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_empty,
   input  rvd_pkg::bundle_type head,
   output logic                q_pop,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output rvd_pkg::rsp_type    rsp_item
);

   logic [1:0] idx_ff, idx_in;
   logic       take;
   logic       last;

   // Present the head bundle one result at a time.
   assign rsp_empty = q_empty;
   assign rsp_item  = head.res[idx_ff];
   assign take      = rsp_pop && !q_empty;
   assign last      = ({1'b0, idx_ff} == head.count - 3'd1);
   assign q_pop     = take && last;

   always_comb begin
      idx_in = idx_ff;
      if (take) idx_in = last ? 2'd0 : idx_ff + 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= 2'd0;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule

FILE: tb/tb_rtp_vvc_depacketizer_core.sv
module tb_rtp_vvc_depacketizer_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int HOLD_CYCLES    = 400;
   localparam int ITEMS_PER_PHASE = 60;

   // Shadow copy of the depacketizer: it turns each accepted payload byte into
   // the results the block should deliver, and checks them as they leave.
   class unit_scoreboard;
      rvd_pkg::rsp_type pending_results[$];
      int          mismatches;
      bit          donl;
      bit          seeded, lost_pending, unit_open, agg_first_unit;
      bit [15:0]   last_seq;
      int unsigned unit_count, packet_pos, bytes_left, agg_phase, agg_unit_left;
      bit [7:0]    held_header[2];
      logic [1:0]  mode;
      bit [31:0]   packet_time;
      bit [1:0]    frag_bits;
      int          nres;

      function void clear();
         donl = 0; seeded = 0; lost_pending = 0; last_seq = 0;
         unit_open = 0; unit_count = 0; held_header[0] = 0; held_header[1] = 0;
         mode = rvd_pkg::MODE_IDLE; packet_pos = 0; bytes_left = 0;
         agg_phase = 0; agg_unit_left = 0; agg_first_unit = 1;
         packet_time = 0; frag_bits = 0;
      endfunction

      function void put(logic [1:0] k, bit [7:0] b, bit f, bit l, bit [31:0] ts,
                        int unsigned len);
         rvd_pkg::rsp_type r;
         if (nres >= rvd_pkg::MAX_RES) return;
         r.kind = k; r.unit_byte = b; r.unit_first = f; r.lost_flag = l;
         r.unit_timestamp = ts; r.unit_length = len[20:0];
         pending_results.push_back(r);
         nres++;
      endfunction

      function void data_byte(bit [7:0] b);
         put(rvd_pkg::KIND_DATA, b, unit_count == 0, 0, 0, 0);
         if (unit_count != 32'hFFFF_FFFF) unit_count++;
      endfunction

      function void end_unit();
         put(rvd_pkg::KIND_END, 0, 0, lost_pending, packet_time, unit_count);
         lost_pending = 0; unit_open = 0; unit_count = 0;
      endfunction

      function void abort_unit();
         if (unit_open) put(rvd_pkg::KIND_ABORT, 0, 0, 0, 0, 0);
         unit_open = 0; unit_count = 0;
      endfunction

      // Close the current packet, as on its last byte.
      function void finish_packet();
         if (mode == rvd_pkg::MODE_SINGLE) begin
            if (packet_pos >= 2) end_unit();
         end else if (mode == rvd_pkg::MODE_AGG) begin
            if (agg_phase == rvd_pkg::AGG_DATA && agg_unit_left > 0) begin
               abort_unit();
               lost_pending = 1;
            end else if (agg_phase >= rvd_pkg::AGG_DONL &&
                         agg_phase <= rvd_pkg::AGG_SIZE_LO) begin
               lost_pending = 1;
            end
         end else if (mode == rvd_pkg::MODE_FRAG) begin
            if (packet_pos >= 3 && unit_open && frag_bits[0]) end_unit();
         end
         mode = rvd_pkg::MODE_IDLE;
      endfunction

      // Aggregation packets: optional order fields, a 16-bit size, then unit bytes.
      function void step_agg(bit [7:0] b, int unsigned rem);
         int unsigned n, len;
         case (agg_phase)
            rvd_pkg::AGG_SIZE_HI0: begin
               n = 2 + (donl ? (agg_first_unit ? 2 : 1) : 0);
               if (rem <= n) begin
                  mode = rvd_pkg::MODE_IDLE;
                  return;
               end
               if (donl) begin
                  agg_phase = agg_first_unit ? rvd_pkg::AGG_DONL : rvd_pkg::AGG_SIZE_HI;
               end else begin
                  agg_unit_left = b << 8;
                  agg_phase = rvd_pkg::AGG_SIZE_LO;
               end
            end
            rvd_pkg::AGG_DONL: agg_phase = rvd_pkg::AGG_SIZE_HI;
            rvd_pkg::AGG_SIZE_HI: begin
               agg_unit_left = b << 8;
               agg_phase = rvd_pkg::AGG_SIZE_LO;
            end
            rvd_pkg::AGG_SIZE_LO: begin
               len = agg_unit_left | b;
               if (len < 3 || rem == 0 || len > rem - 1) begin
                  abort_unit();
                  lost_pending = 1;
                  put(rvd_pkg::KIND_REJECT, 0, 0, 0, 0, 0);
                  agg_phase = rvd_pkg::AGG_SIZE_HI0;
                  mode = rvd_pkg::MODE_IDLE;
                  return;
               end
               abort_unit();
               unit_open = 1; unit_count = 0;
               agg_unit_left = len;
               agg_phase = rvd_pkg::AGG_DATA;
            end
            default: begin
               data_byte(b);
               if (agg_unit_left > 0) agg_unit_left--;
               if (agg_unit_left == 0) begin
                  end_unit();
                  agg_phase = rvd_pkg::AGG_SIZE_HI0;
                  agg_first_unit = 0;
               end
            end
         endcase
      endfunction

      // Fragment header: start and end bits, unit size limit, rebuilt NAL header.
      function void frag_header(bit [7:0] b, int unsigned rem);
         int unsigned extra, dlen, base;
         bit start;
         extra = donl ? 2 : 0;
         dlen = (rem >= 1 + extra) ? rem - 1 - extra : 0;
         start = b[7];
         base = start ? 2 : (unit_open ? unit_count : 0);
         if (longint'(base) + dlen > rvd_pkg::MAX_UNIT_BYTES) begin
            put(rvd_pkg::KIND_REJECT, 0, 0, 0, 0, 0);
            mode = rvd_pkg::MODE_IDLE;
            return;
         end
         if (start) begin
            abort_unit();
            unit_open = 1; unit_count = 0;
            data_byte(held_header[0]);
            data_byte({b[4:0], held_header[1][2:0]});
         end else if (!unit_open) begin
            lost_pending = 1;
            mode = rvd_pkg::MODE_IDLE;
            return;
         end
         frag_bits = {start, b[6]};
      endfunction

      // Note one accepted payload byte and queue what it should produce.
      function void note_byte(rvd_pkg::req_type it);
         int unsigned rem, pos;
         bit [4:0] t;
         nres = 0;
         if (it.packet_first) begin
            if (mode != rvd_pkg::MODE_IDLE) finish_packet();
            if (it.payload_length < (donl ? 5 : 3)) begin
               put(rvd_pkg::KIND_REJECT, 0, 0, 0, 0, 0);
               mode = rvd_pkg::MODE_IDLE;
               return;
            end
            if (!seeded) begin
               seeded = 1;
               last_seq = it.rtp_seq - 16'd1;
            end
            if (it.rtp_seq != last_seq + 16'd1) begin
               lost_pending = 1;
               abort_unit();
            end
            last_seq = it.rtp_seq;
            packet_time = it.rtp_timestamp;
            held_header[0] = it.payload_byte;
            packet_pos = 1;
            bytes_left = it.payload_length - 1;
            mode = rvd_pkg::MODE_SINGLE;
            agg_phase = rvd_pkg::AGG_SIZE_HI0;
            agg_first_unit = 1;
            frag_bits = 0;
            if (it.packet_last || bytes_left == 0) finish_packet();
            return;
         end
         if (mode == rvd_pkg::MODE_IDLE) return;
         rem = bytes_left;
         pos = packet_pos;
         if (mode == rvd_pkg::MODE_SINGLE) begin
            if (pos == 1) begin
               held_header[1] = it.payload_byte;
               t = it.payload_byte[7:3];
               if (t == rvd_pkg::TYPE_AP) begin
                  mode = rvd_pkg::MODE_AGG;
                  agg_phase = rvd_pkg::AGG_SIZE_HI0;
               end else if (t == rvd_pkg::TYPE_FU) begin
                  mode = rvd_pkg::MODE_FRAG;
               end else begin
                  abort_unit();
                  unit_open = 1; unit_count = 0;
                  data_byte(held_header[0]);
                  data_byte(it.payload_byte);
               end
            end else begin
               data_byte(it.payload_byte);
            end
         end else if (mode == rvd_pkg::MODE_AGG) begin
            step_agg(it.payload_byte, rem);
         end else begin
            if (pos == 2) frag_header(it.payload_byte, rem);
            else if (pos >= (donl ? 5 : 3)) data_byte(it.payload_byte);
         end
         packet_pos = (pos + 1) & 16'hFFFF;
         bytes_left = rem > 0 ? rem - 1 : 0;
         if (mode != rvd_pkg::MODE_IDLE && (it.packet_last || bytes_left == 0))
            finish_packet();
      endfunction

      // Compare one delivered result with the oldest expectation.
      function void check_result(rvd_pkg::rsp_type got);
         rvd_pkg::rsp_type want;
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result: %p", got);
            return;
         end
         want = pending_results.pop_front();
         if (got.kind !== want.kind || got.unit_byte !== want.unit_byte ||
             got.unit_first !== want.unit_first || got.lost_flag !== want.lost_flag ||
             got.unit_timestamp !== want.unit_timestamp ||
             got.unit_length !== want.unit_length) begin
            mismatches++;
            if (mismatches <= 10) $display("result mismatch: expected %p, got %p", want, got);
         end
      endfunction
   endclass

   logic    clock, reset;
   logic    req_push, req_full, rsp_empty, rsp_pop, csr_we, csr_wdata;
   rvd_pkg::req_type req_item;
   rvd_pkg::rsp_type rsp_item;

   unit_scoreboard sb;
   bit        calm, hold_req;
   int        sent, idle_cycles;
   bit [15:0] next_seq;
   bit [7:0]  pkt[$];

   rtp_vvc_depacketizer_core dut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_item(req_item),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_item(rsp_item),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   // Offer one item, with an occasional idle burst first; return once it is taken.
   task automatic push_item(rvd_pkg::req_type it);
      if (!calm && $urandom_range(0, 9) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_push <= 1'b1;
      req_item <= it;
      do @(posedge clock); while (req_full);
      sb.note_byte(it);
      sent++;
   endtask

   // Send the bytes in pkt as one packet with the given first-byte fields.
   task automatic send_packet(bit [15:0] seq, bit [15:0] plen, bit mark_last);
      rvd_pkg::req_type it;
      foreach (pkt[i]) begin
         it.payload_byte   = pkt[i];
         it.packet_first   = (i == 0);
         it.packet_last    = mark_last && (i == pkt.size() - 1);
         it.rtp_seq        = (i == 0) ? seq : 16'($urandom);
         it.rtp_timestamp  = $urandom;
         it.payload_length = (i == 0) ? plen : 16'($urandom);
         push_item(it);
      end
   endtask

   // Send pkt in sequence, usually intact, sometimes with a gap, without the last mark,
   // or with a length that disagrees with the bytes actually sent.
   task automatic send_in_order();
      int sel;
      bit [15:0] n;
      if ($urandom_range(0, 19) == 0) next_seq += 16'($urandom_range(1, 3));
      n = 16'(pkt.size());
      sel = $urandom_range(0, 19);
      if (sel < 13)       send_packet(next_seq, n, 1'b1);
      else if (sel < 15)  send_packet(next_seq, n, 1'b0);
      else if (sel < 17)  send_packet(next_seq, n + 16'($urandom_range(1, 9)), 1'b1);
      else if (sel < 18)  send_packet(next_seq, n + 16'($urandom_range(1, 9)), 1'b0);
      else                send_packet(next_seq, n - 16'($urandom_range(0, n - 1)), 1'b1);
      next_seq++;
   endtask

   function automatic void build_single(int n);
      bit [4:0] t;
      do t = 5'($urandom); while (t == rvd_pkg::TYPE_AP || t == rvd_pkg::TYPE_FU);
      pkt = {};
      pkt.push_back(8'($urandom));
      pkt.push_back({t, 3'($urandom)});
      repeat (n) pkt.push_back(8'($urandom));
   endfunction

   // Aggregation packet; a bad unit carries a size too small or too large.
   function automatic void build_agg(int units, bit bad);
      int sz;
      pkt = {};
      pkt.push_back(8'($urandom));
      pkt.push_back({rvd_pkg::TYPE_AP, 3'($urandom)});
      for (int u = 0; u < units; u++) begin
         if (sb.donl) repeat (u == 0 ? 2 : 1) pkt.push_back(8'($urandom));
         sz = $urandom_range(3, 10);
         if (bad && u == units - 1) sz = $urandom_range(0, 1) ? $urandom_range(0, 2) : 300;
         pkt.push_back(8'(sz >> 8));
         pkt.push_back(8'(sz));
         repeat ((bad && u == units - 1) ? 2 : sz) pkt.push_back(8'($urandom));
      end
   endfunction

   function automatic void build_frag(bit s, bit e, bit [4:0] ft, int n);
      pkt = {};
      pkt.push_back(8'($urandom));
      pkt.push_back({rvd_pkg::TYPE_FU, 3'($urandom)});
      pkt.push_back({s, e, 1'b0, ft});
      if (sb.donl) repeat (2) pkt.push_back(8'($urandom));
      repeat (n) pkt.push_back(8'($urandom));
   endfunction

   // A fragmented unit: start, middles and end, now and then without its start.
   task automatic frag_series();
      int mids;
      bit [4:0] ft;
      mids = $urandom_range(0, 2);
      ft = 5'($urandom);
      for (int k = 0; k <= mids + 1; k++) begin
         if (k == 0 && $urandom_range(0, 9) == 0) continue;
         build_frag(k == 0, k == mids + 1, ft, $urandom_range(0, 6));
         send_in_order();
      end
   endtask

   // Let the block settle, then write the order-field setting.
   task automatic write_donl(bit v);
      req_push <= 1'b0;
      while (sb.pending_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      sb.donl = v;
      csr_we <= 1'b0;
   endtask

   // Extremes and corner cases of one setting.
   task automatic directed_part();
      rvd_pkg::req_type it;
      // Stray bytes while no packet is open are ignored.
      it = '0;
      it.payload_byte = 8'hFF;
      push_item(it);
      // Short packets.
      pkt = {8'h00};
      send_packet(next_seq, 16'd0, 1'b1);
      pkt = {8'hFF};
      send_packet(next_seq, sb.donl ? 16'd4 : 16'd2, 1'b1);
      // A single unit cut to one byte is dropped.
      pkt = {8'hFF};
      send_packet(next_seq++, 16'hFFFF, 1'b1);
      pkt = {8'h00, 8'h00, 8'h00};
      send_packet(next_seq++, 16'd3, 1'b1);
      pkt = {8'hFF, 8'hFF, 8'hFF};
      send_packet(next_seq++, 16'd3, 1'b1);
      // Aggregation with a length error.
      build_agg(1, 1'b1);
      send_packet(next_seq++, 16'(pkt.size()), 1'b1);
      // Orphan fragment, then a start-and-end fragment.
      build_frag(1'b0, 1'b1, 5'h1F, 1);
      send_packet(next_seq++, 16'(pkt.size()), 1'b1);
      build_frag(1'b1, 1'b1, 5'h00, 1);
      send_packet(next_seq++, 16'(pkt.size()), 1'b1);
   endtask

   task automatic random_part(int target);
      int sel;
      while (sent < target) begin
         sel = $urandom_range(0, 19);
         if (sel < 5) begin
            build_single($urandom_range(0, 8));
            send_in_order();
         end else if (sel < 10) begin
            build_agg($urandom_range(1, 3), $urandom_range(0, 9) == 0);
            send_in_order();
         end else if (sel < 17) begin
            frag_series();
         end else if (sel < 18) begin
            pkt = {};
            repeat ($urandom_range(1, 4)) pkt.push_back(8'($urandom));
            send_packet(16'($urandom), 16'($urandom_range(0, 6)), 1'($urandom_range(0, 1)));
         end else if (sel < 19) begin
            build_single($urandom_range(100, 200));
            send_in_order();
         end else begin
            pkt = {8'($urandom)};
            send_packet(next_seq++, 16'($urandom), 1'b0);
         end
      end
   endtask

   // Receiver: pops with random stalls and one long hold-off on request.
   initial begin
      int stall;
      stall = 0;
      rsp_pop = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_pop && !rsp_empty) sb.check_result(rsp_item);
         if (hold_req) begin
            hold_req = 0;
            stall = HOLD_CYCLES;
         end else if (stall == 0 && !calm && $urandom_range(0, 11) == 0) begin
            stall = $urandom_range(1, 17);
         end
         if (stall > 0) begin
            stall--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   // Watchdog on cycles with no transfer on either channel.
   initial begin
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_push && !req_full) || (rsp_pop && !rsp_empty)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_rtp_vvc_depacketizer_core failed");
            $finish;
         end
      end
   end

   // Main sequence: reset, then four phases that alternate the order-field setting between off and on.
   initial begin
      sb = new();
      sb.clear();
      reset = 1'b1;
      req_push = 1'b0;
      req_item = '0;
      csr_we = 1'b0;
      csr_wdata = 1'b0;
      calm = 0;
      hold_req = 0;
      sent = 0;
      next_seq = 16'hFFFC;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int ph = 0; ph < 4; ph++) begin
         if (ph > 0) write_donl(ph[0]);
         if (ph == 3) calm = 1;
         directed_part();
         if (ph == 1) hold_req = 1;
         random_part(sent + ITEMS_PER_PHASE);
      end
      req_push <= 1'b0;
      while (sb.pending_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending_results.size() == 0)
         $display("tb_rtp_vvc_depacketizer_core passed");
      else
         $display("tb_rtp_vvc_depacketizer_core failed");
      $finish;
   end

endmodule
